>>> design/chf_pkg.sv
`timescale 1ns / 1ps

package chf_pkg;

    localparam int FRAC_BITS = 16;
    // Root width covers sqrt of a 31-bit value with FRAC_BITS extra fraction bits
    localparam int ROOT_W = (31 + FRAC_BITS + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    // Product of two saturated magnitudes (up to 2^62) plus a shifted shear term
    localparam int NUM_W  = 63;
    // Quotient bits developed; anything at or above 2^QB saturates anyway
    localparam int QB     = 33;
    localparam int HI_W   = NUM_W - QB;

    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
    } sm32_t;

    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] mag;
    } sm63_t;

    // Everything an item needs further down the pipe
    typedef struct packed {
        logic [30:0]       vv;
        logic [30:0]       ww;
        sm32_t             uv;
        sm32_t             uw;
        sm32_t             vw;
        logic [ROOT_W-1:0] f11;
        logic [ROOT_W-1:0] f22;
        sm32_t             f21;
        sm32_t             f31;
        sm32_t             f32;
        sm63_t             num;
        logic [NUM_W-1:0]  sq31;
        logic [NUM_W-1:0]  d31;
        logic              bad31;
        logic              invalid;
    } side_t;

    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [ROOT_W-1:0] rem;
        logic [QB-1:0]     lo;
        logic [QB-1:0]     q;
    } div_lane_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W:0]   rem;
        logic [ROOT_W-1:0] root;
    } sqrt_lane_t;

    function automatic sm32_t from_s32(logic [31:0] v);
        sm32_t r;
        r.neg = v[31];
        r.mag = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

    function automatic logic [31:0] to_s32(sm32_t a);
        return a.neg ? (~a.mag + 32'd1) : a.mag;
    endfunction

    function automatic sm63_t sm_add(sm63_t a, sm63_t b);
        sm63_t r;
        if (a.neg == b.neg) begin
            r.neg = a.neg;
            r.mag = a.mag + b.mag;
        end else if (a.mag >= b.mag) begin
            r.neg = a.neg;
            r.mag = a.mag - b.mag;
        end else begin
            r.neg = b.neg;
            r.mag = b.mag - a.mag;
        end
        if (r.mag == '0)
            r.neg = 1'b0;
        return r;
    endfunction

    // One restoring division step: returns {quotient bit, new remainder}
    function automatic logic [ROOT_W:0] div_step(logic [ROOT_W-1:0] rem, logic b,
                                                 logic [ROOT_W-1:0] d);
        logic [ROOT_W:0] t;
        logic [ROOT_W:0] dx;
        t  = {rem, b};
        dx = {1'b0, d};
        if (t >= dx)
            return {1'b1, ROOT_W'(t - dx)};
        else
            return {1'b0, t[ROOT_W-1:0]};
    endfunction

    // One square-root digit: returns {new root, new remainder}
    function automatic logic [2*ROOT_W:0] sqrt_step(logic [ROOT_W:0] rem,
                                                    logic [ROOT_W-1:0] root,
                                                    logic [1:0] pair);
        logic [ROOT_W+2:0] t;
        logic [ROOT_W+2:0] trial;
        t     = {rem, pair};
        trial = {1'b0, root, 2'b01};
        if (t >= trial)
            return {root[ROOT_W-2:0], 1'b1, (ROOT_W+1)'(t - trial)};
        else
            return {root[ROOT_W-2:0], 1'b0, t[ROOT_W:0]};
    endfunction

    // Clamp a quotient to the signed 32-bit range
    function automatic sm32_t sat_q(logic neg, logic ovf, logic [QB-1:0] q);
        sm32_t         r;
        logic [QB-1:0] lim;
        logic [QB-1:0] m;
        lim = neg ? (QB'(1) << 31) : ((QB'(1) << 31) - QB'(1));
        m   = (ovf || (q > lim)) ? lim : q;
        r.mag = m[31:0];
        r.neg = neg && (r.mag != 32'd0);
        return r;
    endfunction

endpackage

>>> design/chf_sqrt.sv
`timescale 1ns / 1ps

module chf_sqrt
    import chf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  radicand,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output side_t             out_side
);

    logic       valid_reg [ROOT_W+1];
    side_t      side_reg  [ROOT_W+1];
    sqrt_lane_t lane_reg  [ROOT_W+1];

    // Load the radicand with an empty remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0]      <= in_side;
            lane_reg[0].rad  <= radicand;
            lane_reg[0].rem  <= '0;
            lane_reg[0].root <= '0;
        end
    end

    // One root bit per stage, most significant pair first
    for (genvar j = 1; j <= ROOT_W; j++)
    begin : g_step
        logic [2*ROOT_W:0] nxt;

        assign nxt = sqrt_step(lane_reg[j-1].rem, lane_reg[j-1].root,
                               lane_reg[j-1].rad[RAD_W-2*j+1 -: 2]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (en)
                valid_reg[j] <= valid_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j]      <= side_reg[j-1];
                lane_reg[j].rad  <= lane_reg[j-1].rad;
                lane_reg[j].root <= nxt[2*ROOT_W:ROOT_W+1];
                lane_reg[j].rem  <= nxt[ROOT_W:0];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W];
    assign root      = lane_reg[ROOT_W].root;
    assign out_side  = side_reg[ROOT_W];

endmodule

>>> design/chf_div.sv
`timescale 1ns / 1ps

module chf_div
    import chf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  sm63_t             num_a,
    input  sm63_t             num_b,
    input  logic [ROOT_W-1:0] divisor,
    input  side_t             in_side,
    output logic              out_valid,
    output sm32_t             quo_a,
    output sm32_t             quo_b,
    output side_t             out_side
);

    logic              valid_reg [QB+1];
    side_t             side_reg  [QB+1];
    logic [ROOT_W-1:0] d_reg     [QB+1];
    div_lane_t         lane_reg  [QB+1][2];
    sm63_t             num_in    [2];

    assign num_in[0] = num_a;
    assign num_in[1] = num_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    // Flag quotients of 2^QB or more; the rest starts from the high bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            d_reg[0]    <= divisor;
            for (int k = 0; k < 2; k++)
            begin
                lane_reg[0][k].neg <= num_in[k].neg;
                lane_reg[0][k].ovf <= num_in[k].mag[NUM_W-1:QB] >= HI_W'(divisor);
                lane_reg[0][k].rem <= num_in[k].mag[QB+ROOT_W-1:QB];
                lane_reg[0][k].lo  <= num_in[k].mag[QB-1:0];
                lane_reg[0][k].q   <= '0;
            end
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_step
        logic [ROOT_W:0] nxt [2];

        for (genvar k = 0; k < 2; k++)
        begin : g_lane
            assign nxt[k] = div_step(lane_reg[j-1][k].rem, lane_reg[j-1][k].lo[QB-j],
                                     d_reg[j-1]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (en)
                valid_reg[j] <= valid_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j] <= side_reg[j-1];
                d_reg[j]    <= d_reg[j-1];
                for (int k = 0; k < 2; k++)
                begin
                    lane_reg[j][k].neg <= lane_reg[j-1][k].neg;
                    lane_reg[j][k].ovf <= lane_reg[j-1][k].ovf;
                    lane_reg[j][k].lo  <= lane_reg[j-1][k].lo;
                    lane_reg[j][k].rem <= nxt[k][ROOT_W-1:0];
                    lane_reg[j][k].q   <= {lane_reg[j-1][k].q[QB-2:0], nxt[k][ROOT_W]};
                end
            end
        end
    end

    assign out_valid = valid_reg[QB];
    assign out_side  = side_reg[QB];
    assign quo_a = sat_q(lane_reg[QB][0].neg, lane_reg[QB][0].ovf, lane_reg[QB][0].q);
    assign quo_b = sat_q(lane_reg[QB][1].neg, lane_reg[QB][1].ovf, lane_reg[QB][1].q);

endmodule

>>> design/cholesky_factor_3x3_top.sv
`timescale 1ns / 1ps
// Pipeline: an accepted input transaction passes on its way to its result through
//   three 25-stage root units, two 34-stage dividers and five single stages.
// Throughput: one transaction per cycle; the whole pipe advances together and
//   holds only while a result waits in the output register under stall.
// Reset: rst_n clears every valid bit at once; payload registers are not reset.

module cholesky_factor_3x3_top
    import chf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [30:0]        stress_uu,
    input  logic [30:0]        stress_vv,
    input  logic [30:0]        stress_ww,
    input  logic signed [31:0] stress_uv,
    input  logic signed [31:0] stress_uw,
    input  logic signed [31:0] stress_vw,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [30:0]        factor_11,
    output logic signed [31:0] factor_21,
    output logic [30:0]        factor_22,
    output logic signed [31:0] factor_31,
    output logic signed [31:0] factor_32,
    output logic [30:0]        factor_33,
    output logic               invalid
);

    // The pipe moves whenever the output register is empty or being drained
    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // ---- Entry: replace zero normals by one LSB, split shears into sign/magnitude
    logic [30:0]      uu_fix;
    logic [RAD_W-1:0] rad1;
    side_t            side0;

    assign uu_fix = (stress_uu == 31'd0) ? 31'd1 : stress_uu;
    assign rad1   = RAD_W'(uu_fix) << FRAC_BITS;

    always_comb
    begin
        side0         = '0;
        side0.vv      = (stress_vv == 31'd0) ? 31'd1 : stress_vv;
        side0.ww      = (stress_ww == 31'd0) ? 31'd1 : stress_ww;
        side0.uv      = from_s32(stress_uv);
        side0.uw      = from_s32(stress_uw);
        side0.vw      = from_s32(stress_vw);
    end

    // ---- f11 = sqrt(uu)
    logic              s1_valid;
    logic [ROOT_W-1:0] s1_root;
    side_t             s1_side;

    chf_sqrt u_sqrt_11 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .radicand  (rad1),
        .in_side   (side0),
        .out_valid (s1_valid),
        .root      (s1_root),
        .out_side  (s1_side)
    );

    // ---- f21 = uv / f11 and f31 = uw / f11, side by side
    sm63_t  d1_num_a;
    sm63_t  d1_num_b;
    side_t  d1_side_in;
    logic   d1_valid;
    sm32_t  d1_q21;
    sm32_t  d1_q31;
    side_t  d1_side;

    always_comb
    begin
        d1_num_a.neg   = s1_side.uv.neg;
        d1_num_a.mag   = NUM_W'(s1_side.uv.mag) << FRAC_BITS;
        d1_num_b.neg   = s1_side.uw.neg;
        d1_num_b.mag   = NUM_W'(s1_side.uw.mag) << FRAC_BITS;
        d1_side_in     = s1_side;
        d1_side_in.f11 = s1_root;
    end

    chf_div u_div_1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid),
        .num_a     (d1_num_a),
        .num_b     (d1_num_b),
        .divisor   (s1_root),
        .in_side   (d1_side_in),
        .out_valid (d1_valid),
        .quo_a     (d1_q21),
        .quo_b     (d1_q31),
        .out_side  (d1_side)
    );

    // ---- Products of the first column, registered straight after the multipliers
    logic             m_valid_reg;
    logic [NUM_W-1:0] m_sq21_reg;
    logic [NUM_W-1:0] m_prod_reg;
    side_t            m_side_reg;
    side_t            m_side_next;

    always_comb
    begin
        m_side_next      = d1_side;
        m_side_next.f21  = d1_q21;
        m_side_next.f31  = d1_q31;
        m_side_next.sq31 = NUM_W'(d1_q31.mag) * NUM_W'(d1_q31.mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= d1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_sq21_reg <= NUM_W'(d1_q21.mag) * NUM_W'(d1_q21.mag);
            m_prod_reg <= NUM_W'(d1_q21.mag) * NUM_W'(d1_q31.mag);
            m_side_reg <= m_side_next;
        end
    end

    // ---- Second radicand and the numerator of f32
    logic             n_valid_reg;
    logic [RAD_W-1:0] n_rad_reg;
    logic [RAD_W-1:0] n_rad_next;
    side_t            n_side_reg;
    side_t            n_side_next;
    logic [NUM_W-1:0] vvq;
    sm63_t            vw_sh;
    sm63_t            prod;

    always_comb
    begin
        vvq       = NUM_W'(m_side_reg.vv) << FRAC_BITS;
        vw_sh.neg = m_side_reg.vw.neg;
        vw_sh.mag = NUM_W'(m_side_reg.vw.mag) << FRAC_BITS;
        // Subtracting f21*f31: the term is negative when both signs agree
        prod.mag  = m_prod_reg;
        prod.neg  = (m_side_reg.f21.neg == m_side_reg.f31.neg) && (m_prod_reg != '0);
        n_side_next = m_side_reg;
        n_side_next.num = sm_add(vw_sh, prod);
        if (m_sq21_reg > vvq)
        begin
            n_side_next.invalid = 1'b1;
            n_rad_next          = '0;
        end
        else
        begin
            n_rad_next = RAD_W'(vvq - m_sq21_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_valid_reg <= 1'b0;
        else if (en)
            n_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_rad_reg  <= n_rad_next;
            n_side_reg <= n_side_next;
        end
    end

    // ---- f22
    logic              s2_valid;
    logic [ROOT_W-1:0] s2_root;
    side_t             s2_side;

    chf_sqrt u_sqrt_22 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n_valid_reg),
        .radicand  (n_rad_reg),
        .in_side   (n_side_reg),
        .out_valid (s2_valid),
        .root      (s2_root),
        .out_side  (s2_side)
    );

    // ---- f32; a zero f22 divides by one and the quotient is dropped later
    logic              f22_zero;
    logic [ROOT_W-1:0] d2_divisor;
    side_t             d2_side_in;
    logic              d2_valid;
    sm32_t             d2_q32;
    sm32_t             d2_unused;
    side_t             d2_side;

    assign f22_zero   = (s2_root == '0);
    assign d2_divisor = f22_zero ? ROOT_W'(1) : s2_root;

    always_comb
    begin
        d2_side_in         = s2_side;
        d2_side_in.f22     = s2_root;
        d2_side_in.invalid = s2_side.invalid || f22_zero;
    end

    chf_div u_div_2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid),
        .num_a     (s2_side.num),
        .num_b     ('0),
        .divisor   (d2_divisor),
        .in_side   (d2_side_in),
        .out_valid (d2_valid),
        .quo_a     (d2_q32),
        .quo_b     (d2_unused),
        .out_side  (d2_side)
    );

    // ---- Square of f32, and ww less f31 squared alongside it
    logic             p_valid_reg;
    logic [NUM_W-1:0] p_sq32_reg;
    side_t            p_side_reg;
    side_t            p_side_next;
    sm32_t            f32_kept;
    logic [NUM_W-1:0] wwq;

    always_comb
    begin
        f32_kept = (d2_side.f22 == '0) ? '0 : d2_q32;
        wwq      = NUM_W'(d2_side.ww) << FRAC_BITS;
        p_side_next       = d2_side;
        p_side_next.f32   = f32_kept;
        p_side_next.bad31 = d2_side.sq31 > wwq;
        p_side_next.d31   = wwq - d2_side.sq31;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_sq32_reg <= NUM_W'(f32_kept.mag) * NUM_W'(f32_kept.mag);
            p_side_reg <= p_side_next;
        end
    end

    // ---- Third radicand
    logic             r_valid_reg;
    logic [RAD_W-1:0] r_rad_reg;
    logic [RAD_W-1:0] r_rad_next;
    side_t            r_side_reg;
    side_t            r_side_next;
    logic             skip3;
    logic             bad3;

    always_comb
    begin
        skip3 = (p_side_reg.f22 == '0);
        bad3  = p_side_reg.bad31 || (p_sq32_reg > p_side_reg.d31);
        r_side_next = p_side_reg;
        if (skip3 || bad3)
        begin
            r_rad_next = '0;
            if (!skip3)
                r_side_next.invalid = 1'b1;
        end
        else
        begin
            r_rad_next = RAD_W'(p_side_reg.d31 - p_sq32_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_valid_reg <= 1'b0;
        else if (en)
            r_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_rad_reg  <= r_rad_next;
            r_side_reg <= r_side_next;
        end
    end

    // ---- f33
    logic              s3_valid;
    logic [ROOT_W-1:0] s3_root;
    side_t             s3_side;

    chf_sqrt u_sqrt_33 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid_reg),
        .radicand  (r_rad_reg),
        .in_side   (r_side_reg),
        .out_valid (s3_valid),
        .root      (s3_root),
        .out_side  (s3_side)
    );

    // ---- Output register; hold the transaction while the sink stalls
    logic              o_valid_reg;
    side_t             o_side_reg;
    logic [ROOT_W-1:0] o_f33_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= s3_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_side_reg <= s3_side;
            o_f33_reg  <= s3_root;
        end
    end

    assign out_valid = o_valid_reg;
    assign factor_11 = 31'(o_side_reg.f11);
    assign factor_21 = to_s32(o_side_reg.f21);
    assign factor_22 = 31'(o_side_reg.f22);
    assign factor_31 = to_s32(o_side_reg.f31);
    assign factor_32 = to_s32(o_side_reg.f32);
    assign factor_33 = 31'(o_f33_reg);
    assign invalid   = o_side_reg.invalid;

endmodule

>>> design/chf_checker.sv
`timescale 1ns / 1ps

module chf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [30:0] factor_11,
    input logic [30:0] factor_22,
    input logic [31:0] factor_32,
    input logic [30:0] factor_33,
    input logic        invalid
);

    // A stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");

    // Input is held back only by a blocked output
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // The first root is never zero
    a_f11: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> factor_11 != 31'd0)
        else $error("factor_11 is zero");

    // A zero second diagonal flags the tensor and clears the third row tail
    a_f22: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && factor_22 == 31'd0 |-> invalid && factor_32 == 32'd0
                                            && factor_33 == 31'd0)
        else $error("zero factor_22 not handled");

endmodule

bind cholesky_factor_3x3_top chf_checker u_chf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .factor_11 (factor_11),
    .factor_22 (factor_22),
    .factor_32 (factor_32),
    .factor_33 (factor_33),
    .invalid   (invalid)
);
